@@ rtl/bcdct_pkg.sv @@
`default_nettype none
package bcdct_pkg;

	// event kinds
	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_KEY    = 2'd1;
	localparam logic [1:0] FUNC_EXPIRY = 2'd2;

	// key codes
	localparam logic [7:0] KEY_PLUS   = 8'h2B;
	localparam logic [7:0] KEY_STAR   = 8'h2A;
	localparam logic [7:0] KEY_EQUALS = 8'h3D;
	localparam logic [7:0] KEY_ZERO   = 8'h30;
	localparam logic [7:0] KEY_NINE   = 8'h39;

	localparam logic [7:0] BCD_59    = 8'h59;
	localparam logic [7:0] BCD_ZERO  = 8'h00;
	localparam logic [7:0] DIGIT_OFS = 8'd48;
	localparam logic [7:0] LOW_MASK  = 8'd15;

	// reset contents of the three digit-pair cells
	localparam logic [7:0] RST_HOURS   = 8'h00;
	localparam logic [7:0] RST_MINUTES = 8'h00;
	localparam logic [7:0] RST_SECONDS = 8'h15;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] key_code;
	} ev_t;

	typedef struct packed {
		logic [7:0] shown_hours;
		logic [7:0] shown_minutes;
		logic [7:0] shown_seconds;
		logic       is_running;
		logic       is_editing;
		logic       is_repeating;
		logic       tick_enabled;
		logic       arm_alarm;
		logic       cancel_alarm;
		logic       countdown_done;
	} res_t;

	// per-word command to the cell chain, already qualified by accept
	typedef struct packed {
		logic load;
		logic clr_rem;
		logic clr_pre;
		logic shift;
		logic tick;
	} cmd_t;

	// flags after the word, plus this word's pulses
	typedef struct packed {
		logic running;
		logic editing;
		logic repeating;
		logic ticking;
		logic arm;
		logic cancel;
		logic done;
	} stat_t;

endpackage
`default_nettype wire

@@ rtl/bcdct_cell.sv @@
`default_nettype none
module bcdct_cell #(
	parameter logic [7:0] RST_VAL = 8'h00
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bcdct_pkg::cmd_t   cmd,
	input  wire logic              borrow_in,
	input  wire logic              nz_in,
	input  wire logic [3:0]        digit_in,
	output logic                   borrow_out,
	output logic                   nz_out,
	output logic [3:0]             digit_out,
	output logic [7:0]             rem_d,
	output logic [7:0]             pre_d
);
	import bcdct_pkg::*;

	logic [7:0] rem_q;
	logic [7:0] pre_q;

	// pair read as hi*10+lo, minus one, re-encoded; tens via reciprocal 205/2048
	function automatic logic [7:0] bcd_dec(input logic [7:0] v);
		logic [7:0]  d;
		logic [15:0] p;
		logic [4:0]  tens;
		logic [7:0]  ones;
		d    = 8'({4'd0, v[7:4]} * 8'd10) + (v & LOW_MASK) - 8'd1;
		p    = 16'(d) * 16'd205;
		tens = p[15:11];
		ones = d - 8'({3'd0, tens} * 8'd10);
		return {tens[3:0], ones[3:0]};
	endfunction

	assign borrow_out = borrow_in & (rem_q == BCD_ZERO);
	assign nz_out     = nz_in | (rem_q != BCD_ZERO);
	assign digit_out  = pre_q[7:4];

	always_comb begin
		rem_d = rem_q;
		pre_d = pre_q;
		if (cmd.load)
			rem_d = pre_q;
		if (cmd.clr_rem)
			rem_d = BCD_ZERO;
		if (cmd.tick && borrow_in) begin
			if (rem_q != BCD_ZERO)
				rem_d = bcd_dec(rem_q);
			else if (nz_in)
				rem_d = BCD_59;
		end
		if (cmd.clr_pre)
			pre_d = BCD_ZERO;
		if (cmd.shift)
			pre_d = {pre_q[3:0], digit_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= RST_VAL;
			pre_q <= RST_VAL;
		end else begin
			rem_q <= rem_d;
			pre_q <= pre_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/bcdct_ctrl.sv @@
`default_nettype none
module bcdct_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire bcdct_pkg::ev_t   ev,
	input  wire logic             all_zero,
	output bcdct_pkg::cmd_t       cmd,
	output bcdct_pkg::stat_t      stat
);
	import bcdct_pkg::*;

	logic running_q, editing_q, repeating_q, ticking_q;
	logic tick, expiry, plus, star, equals, digit, zero;

	always_comb begin
		tick   = accept && (ev.func == FUNC_TICK);
		expiry = accept && (ev.func == FUNC_EXPIRY);
		plus   = accept && (ev.func == FUNC_KEY) && (ev.key_code == KEY_PLUS);
		star   = accept && (ev.func == FUNC_KEY) && (ev.key_code == KEY_STAR);
		equals = accept && (ev.func == FUNC_KEY) && (ev.key_code == KEY_EQUALS);
		digit  = accept && (ev.func == FUNC_KEY) &&
			(ev.key_code >= KEY_ZERO) && (ev.key_code <= KEY_NINE);
		zero   = accept && (ev.func == FUNC_KEY) && (ev.key_code == KEY_ZERO);
	end

	always_comb begin
		cmd.load    = ((plus | equals) & ~running_q & editing_q) |
			(zero & ~editing_q & ~running_q) | expiry;
		cmd.clr_rem = expiry & ~repeating_q;
		cmd.clr_pre = equals & ~running_q & ~editing_q;
		cmd.shift   = digit & editing_q;
		cmd.tick    = tick & running_q;
	end

	always_comb begin
		stat.running   = running_q;
		stat.editing   = editing_q;
		stat.repeating = repeating_q ^ star;
		stat.ticking   = ticking_q;
		stat.arm       = (plus & ~running_q) | (expiry & repeating_q);
		stat.cancel    = plus & running_q;
		stat.done      = expiry;
		if (plus) begin
			stat.running = ~running_q;
			stat.ticking = ~running_q;
			if (~running_q)
				stat.editing = 1'b0;
		end
		if (equals && !running_q)
			stat.editing = ~editing_q;
		if (expiry && !repeating_q)
			stat.running = 1'b0;
		// a tick while stopped, or with time held at zero, stops the tick request
		if (tick && (!running_q || all_zero))
			stat.ticking = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			editing_q   <= 1'b0;
			repeating_q <= 1'b0;
			ticking_q   <= 1'b0;
		end else begin
			running_q   <= stat.running;
			editing_q   <= stat.editing;
			repeating_q <= stat.repeating;
			ticking_q   <= stat.ticking;
		end
	end
endmodule
`default_nettype wire

@@ rtl/bcdct_skid.sv @@
`default_nettype none
module bcdct_skid (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire bcdct_pkg::res_t  din,
	output logic                  room,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output bcdct_pkg::res_t       res
);
	import bcdct_pkg::*;

	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;

	assign room      = ~skid_valid_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || res_ready)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q  <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || res_ready)
				out_q <= din;
			else
				skid_q <= din;
		end else if (res_ready && skid_valid_q) begin
			out_q <= skid_q;
		end
	end
endmodule
`default_nettype wire

@@ rtl/bcd_countdown_timer_keypad.sv @@
// BCD HH:MM:SS countdown timer, event driven.
// Event channel (ev_valid/ev_ready/ev): one word per event, func selects a
// one-second tick, a key press (key_code in ASCII) or an expiry alarm.
// Result channel (res_valid/res_ready/res): exactly one word per event,
// showing the preset while editing or the remaining time otherwise, the
// mode flags after the event and the arm/cancel/done pulses.
// Each result word is registered: output register, or skid word if held.
// Throughput: one event per cycle while ev_ready is high; all state
// updates in the cycle of acceptance through a row of three digit-pair
// cells (seconds, minutes, hours) that ripple the borrow upward, the
// nonzero-above flag downward and the shifted preset digit upward.
// Stall: results go to an output register backed by one skid word, so an
// event is still taken while one result waits; ev_ready drops only when
// both are full.
// Reset: remaining time and preset 00:00:15, all flags clear, no result
// pending.
`default_nettype none
module bcd_countdown_timer_keypad (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ev_valid,
	output logic                  ev_ready,
	input  wire bcdct_pkg::ev_t   ev,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output bcdct_pkg::res_t       res
);
	import bcdct_pkg::*;

	logic  accept;
	cmd_t  cmd, cmd_sec;
	stat_t stat;
	res_t  res_d;

	// cell chain links
	logic       bor_s2m, bor_m2h, bor_top;
	logic       nz_h2m, nz_m2s, nz_unused;
	logic [3:0] dig_s2m, dig_m2h, dig_top;
	logic [7:0] rem_h, rem_m, rem_s, pre_h, pre_m, pre_s;

	assign accept = ev_valid & ev_ready;

	bcdct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.ev       (ev),
		.all_zero (bor_top),
		.cmd      (cmd),
		.stat     (stat)
	);

	// only the seconds cell clears its remaining value on a non-repeat expiry
	always_comb begin
		cmd_sec = cmd;
	end

	cmd_t cmd_upper;
	always_comb begin
		cmd_upper         = cmd;
		cmd_upper.clr_rem = 1'b0;
	end

	bcdct_cell #(.RST_VAL(RST_SECONDS)) u_sec (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_sec),
		.borrow_in  (1'b1),
		.nz_in      (nz_m2s),
		.digit_in   (4'((ev.key_code - DIGIT_OFS) & LOW_MASK)),
		.borrow_out (bor_s2m),
		.nz_out     (nz_unused),
		.digit_out  (dig_s2m),
		.rem_d      (rem_s),
		.pre_d      (pre_s)
	);

	bcdct_cell #(.RST_VAL(RST_MINUTES)) u_min (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_upper),
		.borrow_in  (bor_s2m),
		.nz_in      (nz_h2m),
		.digit_in   (dig_s2m),
		.borrow_out (bor_m2h),
		.nz_out     (nz_m2s),
		.digit_out  (dig_m2h),
		.rem_d      (rem_m),
		.pre_d      (pre_m)
	);

	// top digit of hours drops out on a shift
	bcdct_cell #(.RST_VAL(RST_HOURS)) u_hrs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_upper),
		.borrow_in  (bor_m2h),
		.nz_in      (1'b0),
		.digit_in   (dig_m2h),
		.borrow_out (bor_top),
		.nz_out     (nz_h2m),
		.digit_out  (dig_top),
		.rem_d      (rem_h),
		.pre_d      (pre_h)
	);

	always_comb begin
		res_d.shown_hours    = stat.editing ? pre_h : rem_h;
		res_d.shown_minutes  = stat.editing ? pre_m : rem_m;
		res_d.shown_seconds  = stat.editing ? pre_s : rem_s;
		res_d.is_running     = stat.running;
		res_d.is_editing     = stat.editing;
		res_d.is_repeating   = stat.repeating;
		res_d.tick_enabled   = stat.ticking;
		res_d.arm_alarm      = stat.arm;
		res_d.cancel_alarm   = stat.cancel;
		res_d.countdown_done = stat.done;
	end

	bcdct_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.din       (res_d),
		.room      (ev_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// editing is only entered while stopped, and start leaves it
	a_edit_not_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.is_running && res.is_editing))
		else $error("running and editing both set");

	a_arm_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.arm_alarm && res.cancel_alarm))
		else $error("arm and cancel in one word");

	// a taken event always yields a result word on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid)
		else $error("accepted event produced no result");

	// a pause stops the countdown and the tick request together
	a_cancel_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.cancel_alarm) |-> (!res.is_running && !res.tick_enabled))
		else $error("cancel with timer still running");

	// hours digit shifted out is discarded; shown here only to keep it tied
	logic unused_ok;
	assign unused_ok = nz_unused ^ (|dig_top);
endmodule
`default_nettype wire
